// ----- hw/rtl/rbw_pkg.sv -----
// shared types and constants for the relocation table walker
package rbw_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_PATCH = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// position within a relocation block
	typedef enum logic [2:0] {
		PH_PAGE_LO = 3'd0,
		PH_PAGE_HI = 3'd1,
		PH_SIZE_LO = 3'd2,
		PH_SIZE_HI = 3'd3,
		PH_ENTRY   = 3'd4
	} phase_t;

	// configuration register indexes
	localparam logic CFG_NEW_BASE = 1'b0;
	localparam logic CFG_OLD_BASE = 1'b1;

	// entry decoding
	localparam int unsigned TYPE_SHIFT   = 12;
	localparam logic [3:0]  TYPE_PAD     = 4'd0;
	localparam logic [3:0]  TYPE_HIGHLOW = 4'd3;
	localparam logic [11:0] OFFSET_MASK  = 12'hFFF;
	localparam logic [31:0] HEADER_BYTES = 32'd8;

	// one result word
	typedef struct packed {
		kind_t       kind;
		logic [31:0] patch_address;
		logic [31:0] delta;
	} res_t;

	// base addresses
	typedef struct packed {
		logic [31:0] new_base;
		logic [31:0] old_base;
	} cfg_t;

endpackage

// ----- hw/rtl/pe_base_relocation_walker_top.sv -----
// top level of the relocation table walker
//
//  channel | dir | signals                         | contents
//  s       | in  | s_tvalid s_tready s_tdata[15:0] | table halfword
//  m       | out | m_tvalid m_tready m_tdata m_tuser | patch address, delta, kind
//  cfg     | in  | cfg_we cfg_addr cfg_data        | new_base (0), old_base (1)
//
// one halfword per cycle sustained while m_tready is high; a result is presented once
// its halfword passes the input register, decode and adders, and the result register
// arst_n clears the walker to expect a page header and both bases to zero
// a result held by a low m_tready holds the input register, whatever the next halfword
// is; s_tready then drops as soon as the input register is full
module pe_base_relocation_walker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] table_halfword
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // [31:0] patch_address, [63:32] delta
	output logic [1:0]  m_tuser,  // [1:0] kind
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [31:0] cfg_data
);

	logic          valid_s1;
	logic [15:0]   word_s1;
	logic          take;
	logic          res_valid;
	rbw_pkg::res_t res;
	rbw_pkg::res_t res_q;
	rbw_pkg::cfg_t cfg_q;

	// base address registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			if (cfg_addr == rbw_pkg::CFG_NEW_BASE) begin
				cfg_q.new_base <= cfg_data;
			end else begin
				cfg_q.old_base <= cfg_data;
			end
		end
	end

	// held word moves on when the result register can take it
	assign take = valid_s1 && (!m_tvalid || m_tready);

	rbw_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_tvalid),
		.s_ready  (s_tready),
		.s_word   (s_tdata),
		.take     (take),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	rbw_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (take),
		.word      (word_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	rbw_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (res_valid),
		.res     (res),
		.m_ready (m_tready),
		.m_valid (m_tvalid),
		.res_q   (res_q)
	);

	// output word packing
	assign m_tdata = {res_q.delta, res_q.patch_address};
	assign m_tuser = res_q.kind;

endmodule

// ----- hw/rtl/rbw_in_stage.sv -----
// input register stage for table halfwords
module rbw_in_stage (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_valid,
	output logic        s_ready,
	input  logic [15:0] s_word,
	input  logic        take,
	output logic        valid_s1,
	output logic [15:0] word_s1
);

	// accept when empty or when the held word moves on this cycle
	assign s_ready = !valid_s1 || take;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_ready) begin
			valid_s1 <= s_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_ready && s_valid) begin
			word_s1 <= s_word;
		end
	end

endmodule

// ----- hw/rtl/rbw_parse.sv -----
// table walker state machine and patch arithmetic
module rbw_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [15:0]   word,
	input  rbw_pkg::cfg_t cfg,
	output logic          res_valid,
	output rbw_pkg::res_t res
);

	rbw_pkg::phase_t phase_q, phase_d;
	logic [15:0] page_lo_q;
	logic [31:0] page_q;
	logic [15:0] size_lo_q;
	logic [30:0] entries_q, entries_d;
	logic        first_q, first_d;
	logic        halted_q, halted_d;

	logic [31:0] page_full;
	logic [31:0] size_full;
	logic        size_bad;
	logic [31:0] size_body;
	logic [3:0]  etype;
	logic        last_entry;

	// header and entry decode
	assign page_full  = {word, page_lo_q};
	assign size_full  = {word, size_lo_q};
	assign size_bad   = (size_full < rbw_pkg::HEADER_BYTES) || size_full[0];
	assign size_body  = size_full - rbw_pkg::HEADER_BYTES;
	assign etype      = word[15:rbw_pkg::TYPE_SHIFT];
	assign last_entry = (entries_q == 31'd1);

	// next state
	always_comb begin
		phase_d   = phase_q;
		entries_d = entries_q;
		first_d   = first_q;
		halted_d  = halted_q;
		if (!halted_q) begin
			unique case (phase_q)
				rbw_pkg::PH_PAGE_LO: begin
					phase_d = rbw_pkg::PH_PAGE_HI;
				end
				rbw_pkg::PH_PAGE_HI: begin
					if (!first_q && page_full == 32'd0) begin
						halted_d = 1'b1;
					end else begin
						phase_d = rbw_pkg::PH_SIZE_LO;
					end
				end
				rbw_pkg::PH_SIZE_LO: begin
					phase_d = rbw_pkg::PH_SIZE_HI;
				end
				rbw_pkg::PH_SIZE_HI: begin
					if (size_bad) begin
						halted_d = 1'b1;
					end else begin
						entries_d = size_body[31:1];
						if (size_body[31:1] == 31'd0) begin
							phase_d = rbw_pkg::PH_PAGE_LO;
							first_d = 1'b0;
						end else begin
							phase_d = rbw_pkg::PH_ENTRY;
						end
					end
				end
				rbw_pkg::PH_ENTRY: begin
					if (etype != rbw_pkg::TYPE_HIGHLOW && etype != rbw_pkg::TYPE_PAD) begin
						halted_d = 1'b1;
					end else begin
						entries_d = entries_q - 31'd1;
						if (last_entry) begin
							phase_d = rbw_pkg::PH_PAGE_LO;
							first_d = 1'b0;
						end
					end
				end
				default: begin
					phase_d = rbw_pkg::PH_PAGE_LO;
				end
			endcase
		end
	end

	// result word
	always_comb begin
		res_valid         = 1'b0;
		res.kind          = rbw_pkg::KIND_PATCH;
		res.patch_address = 32'd0;
		res.delta         = 32'd0;
		if (step && !halted_q) begin
			unique case (phase_q)
				rbw_pkg::PH_PAGE_HI: begin
					if (!first_q && page_full == 32'd0) begin
						res_valid = 1'b1;
						res.kind  = rbw_pkg::KIND_DONE;
					end
				end
				rbw_pkg::PH_SIZE_HI: begin
					if (size_bad) begin
						res_valid = 1'b1;
						res.kind  = rbw_pkg::KIND_ERROR;
					end
				end
				rbw_pkg::PH_ENTRY: begin
					if (etype == rbw_pkg::TYPE_HIGHLOW) begin
						res_valid         = 1'b1;
						res.patch_address = cfg.new_base + page_q
							+ {20'd0, word[11:0] & rbw_pkg::OFFSET_MASK};
						res.delta         = cfg.new_base - cfg.old_base;
					end else if (etype != rbw_pkg::TYPE_PAD) begin
						res_valid = 1'b1;
						res.kind  = rbw_pkg::KIND_ERROR;
					end
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= rbw_pkg::PH_PAGE_LO;
			page_lo_q <= 16'd0;
			page_q    <= 32'd0;
			size_lo_q <= 16'd0;
			entries_q <= 31'd0;
			first_q   <= 1'b1;
			halted_q  <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			entries_q <= entries_d;
			first_q   <= first_d;
			halted_q  <= halted_d;
			if (!halted_q && phase_q == rbw_pkg::PH_PAGE_LO) begin
				page_lo_q <= word;
			end
			if (!halted_q && phase_q == rbw_pkg::PH_PAGE_HI) begin
				page_q <= page_full;
			end
			if (!halted_q && phase_q == rbw_pkg::PH_SIZE_LO) begin
				size_lo_q <= word;
			end
		end
	end

	// once halted, stays halted until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("walker left halted state");

	// no results while halted
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !res_valid)
		else $error("result produced while halted");

	// done or error always halts the walk
	a_end_halts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind != rbw_pkg::KIND_PATCH |=> halted_q)
		else $error("final result without halt");

	// patches come only from entry halfwords
	a_patch_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == rbw_pkg::KIND_PATCH |-> phase_q == rbw_pkg::PH_ENTRY)
		else $error("patch outside entry phase");

endmodule

// ----- hw/rtl/rbw_out_stage.sv -----
// output result register
module rbw_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  rbw_pkg::res_t res,
	input  logic          m_ready,
	output logic          m_valid,
	output rbw_pkg::res_t res_q
);

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid <= 1'b0;
		end else if (load) begin
			m_valid <= 1'b1;
		end else if (m_ready) begin
			m_valid <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule
